// ===== src/fbfs_pkg.sv =====
`timescale 1ns / 1ps

package fbfs_pkg;

  localparam int unsigned BlockSizeW = 13;
  localparam int unsigned IndexW     = 8;
  localparam int unsigned OffsetW    = 20;
  localparam int unsigned FreeLeftW  = 9;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] ST_FREE_FULL  = 2'd2;

  localparam logic [OffsetW-1:0] OFFSET_MAX = '1;

  typedef struct packed {
    logic              kind;
    logic [IndexW-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IndexW-1:0]    granted_index;
    logic [OffsetW-1:0]   byte_offset;
    logic [FreeLeftW-1:0] free_left;
  } rsp_t;

endpackage

// ===== src/fixed_block_free_stack_allocator.sv =====
`timescale 1ns / 1ps

// channel   | direction | handshake                   | beat
// ----------+-----------+-----------------------------+-----------------------------
// request   | in        | start high, busy low        | req_i: kind, block_index
// result    | out       | res_valid_o, one cycle      | rsp_o: status, index, offset,
//           |           |                             |        free_left
// config    | in        | cfg_valid_i and cfg_ready_o | cfg_data_i: block_size
//
// for each request, the accept cycle issues the stack memory access and
// the pointer update, the next cycle multiplies the read data by block size and
// registers the result, which shows for one cycle while the next request is accepted.
// reset leaves the stack memory unwritten: a low-water mark of the stack pointer
// tells which entries still hold their reset value, so no clearing pass is run.
// the result side cannot stall; config is always ready.

module fixed_block_free_stack_allocator #(
  parameter int unsigned BLOCK_COUNT = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  fbfs_pkg::req_t                  req_i,
  output logic                            res_valid_o,
  output fbfs_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fbfs_pkg::BlockSizeW-1:0] cfg_data_i
);

  import fbfs_pkg::*;

  localparam int unsigned AW   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned TopW = $clog2(BLOCK_COUNT + 1);
  localparam logic [TopW-1:0] TopFull = TopW'(BLOCK_COUNT);
  localparam int unsigned ProdW = IndexW + BlockSizeW;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  logic [IndexW-1:0] mem [BLOCK_COUNT];
  logic [IndexW-1:0] rd_data_q;

  logic [TopW-1:0]       top_q;
  logic [TopW-1:0]       low_q;
  logic [BlockSizeW-1:0] block_size_q;

  logic [1:0]        status_q;
  logic              from_mem_q;
  logic [IndexW-1:0] index_q;
  logic              accept;

  logic [TopW-1:0] top_dec;
  logic [AW-1:0]   pop_addr;
  logic [31:0]     pop_addr_ext;
  logic [31:0]     top_ext;
  logic            do_pop;
  logic            do_push;

  logic [IndexW-1:0] granted;
  logic [ProdW-1:0]  prod;
  logic [OffsetW-1:0] offset;

  assign accept       = start && (state_q == S_IDLE);
  assign busy         = (state_q != S_IDLE);
  assign cfg_ready_o  = 1'b1;

  assign top_dec      = top_q - TopW'(1);
  assign pop_addr     = top_dec[AW-1:0];
  assign pop_addr_ext = 32'(pop_addr);
  assign top_ext      = 32'(top_q);
  assign do_pop       = accept && (req_i.kind == KIND_ALLOC) && (top_q != '0);
  assign do_push      = accept && (req_i.kind == KIND_FREE) && (top_q < TopFull);

  // stack memory: written on a push, read every cycle; the read from the accept cycle serves a pop
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[top_q[AW-1:0]] <= req_i.block_index;
    end
    rd_data_q <= mem[pop_addr];
  end

  always_comb begin
    granted = from_mem_q ? rd_data_q : index_q;
    prod    = ProdW'(granted) * ProdW'(block_size_q);
    if (prod > ProdW'(OFFSET_MAX)) begin
      offset = OFFSET_MAX;
    end else begin
      offset = prod[OffsetW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      top_q        <= TopFull;
      low_q        <= TopFull;
      block_size_q <= BlockSizeW'(1);
      res_valid_o  <= 1'b0;
      status_q     <= ST_DONE;
      from_mem_q   <= 1'b0;
      index_q      <= '0;
      rsp_o        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        block_size_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          res_valid_o <= 1'b0;
          if (accept) begin
            state_q <= S_EXEC;
            if (do_pop) begin
              top_q <= top_dec;
              // entries below the low-water mark were never written
              if (top_dec < low_q) begin
                low_q      <= top_dec;
                from_mem_q <= 1'b0;
              end else begin
                from_mem_q <= 1'b1;
              end
              index_q  <= pop_addr_ext[IndexW-1:0];
              status_q <= ST_DONE;
            end else if (do_push) begin
              top_q      <= top_q + TopW'(1);
              from_mem_q <= 1'b0;
              index_q    <= req_i.block_index;
              status_q   <= ST_DONE;
            end else begin
              from_mem_q <= 1'b0;
              index_q    <= '0;
              status_q   <= (req_i.kind == KIND_ALLOC) ? ST_ALLOC_FAIL : ST_FREE_FULL;
            end
          end
        end
        S_EXEC: begin
          state_q                <= S_IDLE;
          res_valid_o            <= 1'b1;
          rsp_o.status           <= status_q;
          rsp_o.free_left        <= top_ext[FreeLeftW-1:0];
          if (status_q == ST_DONE) begin
            rsp_o.granted_index <= granted;
            rsp_o.byte_offset   <= offset;
          end else begin
            rsp_o.granted_index <= '0;
            rsp_o.byte_offset   <= '0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          res_valid_o <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fbfs_pkg::*;

  localparam int unsigned Blocks        = 256;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned ItemsPerPhase = 315;
  localparam int unsigned Phases        = 6;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  req_t                  req_i;
  logic                  res_valid_o;
  rsp_t                  rsp_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [BlockSizeW-1:0] cfg_data_i;

  // predicted pool state
  logic [IndexW-1:0]     stack_mem [Blocks];
  int unsigned           top_cnt;
  logic [BlockSizeW-1:0] blk_size;
  logic [IndexW-1:0]     held [$];
  rsp_t                  grants_due [$];
  rsp_t                  want;

  int errors = 0;
  int cycles = 0;
  int n_alloc = 0;
  int n_empty = 0;
  int n_free = 0;
  int n_full = 0;
  int n_sizes = 0;

  fixed_block_free_stack_allocator #(
    .BLOCK_COUNT(Blocks)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("FAIL fixed_block_free_stack_allocator");
      $finish;
    end
  end

  function automatic rsp_t pool_apply(req_t r);
    rsp_t              o;
    logic [IndexW-1:0] idx;
    logic [31:0]       prod;
    o = '0;
    o.status = ST_DONE;
    if (r.kind == KIND_ALLOC) begin
      if (top_cnt > 0) begin
        top_cnt--;
        idx = stack_mem[top_cnt];
        held.push_back(idx);
        o.granted_index = idx;
        n_alloc++;
      end else begin
        o.status = ST_ALLOC_FAIL;
        n_empty++;
      end
    end else begin
      if (top_cnt < Blocks) begin
        stack_mem[top_cnt] = r.block_index;
        top_cnt++;
        o.granted_index = r.block_index;
        n_free++;
      end else begin
        o.status = ST_FREE_FULL;
        n_full++;
      end
    end
    if (o.status == ST_DONE) begin
      prod = 32'(o.granted_index) * 32'(blk_size);
      o.byte_offset = (prod > 32'(OFFSET_MAX)) ? OFFSET_MAX : prod[OffsetW-1:0];
    end
    o.free_left = top_cnt[FreeLeftW-1:0];
    return o;
  endfunction

  function automatic row_t mk_row(logic kind, int idx, bit typed, logic [1:0] st,
                                  int grant, int offs, int left);
    row_t w;
    w.req.kind              = kind;
    w.req.block_index       = IndexW'(idx);
    w.typed                 = typed;
    w.rsp.status            = st;
    w.rsp.granted_index     = IndexW'(grant);
    w.rsp.byte_offset       = OffsetW'(offs);
    w.rsp.free_left         = FreeLeftW'(left);
    return w;
  endfunction

  task automatic issue(input req_t r, input int gap, input bit typed, input rsp_t typed_rsp);
    rsp_t p;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    p = pool_apply(r);
    grants_due.push_back(typed ? typed_rsp : p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_block_size(input logic [BlockSizeW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    blk_size = v;
    n_sizes++;
  endtask

  // result beats cannot be held off: check each one on the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (grants_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing outstanding, got %h", $time, rsp_o);
      end else begin
        want = grants_due.pop_front();
        if (rsp_o.status !== want.status || rsp_o.granted_index !== want.granted_index ||
            rsp_o.byte_offset !== want.byte_offset || rsp_o.free_left !== want.free_left) begin
          errors++;
          $display({"%0t: mismatch status exp %0d got %0d, index exp %0d got %0d, ",
                    "offset exp %0d got %0d, free_left exp %0d got %0d"},
                   $time, want.status, rsp_o.status, want.granted_index,
                   rsp_o.granted_index, want.byte_offset, rsp_o.byte_offset,
                   want.free_left, rsp_o.free_left);
        end
      end
    end
  end

  initial begin
    row_t                  rows [$];
    req_t                  r;
    int                    gap;
    int                    k;
    bit                    quiet;
    bit                    draining;
    logic [BlockSizeW-1:0] sizes [Phases];
    int                    idle_pct [Phases];

    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    for (int i = 0; i < Blocks; i++) stack_mem[i] = IndexW'(i);
    top_cnt  = Blocks;
    blk_size = BlockSizeW'(1);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset block size of 1: offsets equal indices
    rows.push_back(mk_row(KIND_FREE,  8'h55, 1, ST_FREE_FULL, 0, 0, 256));
    rows.push_back(mk_row(KIND_ALLOC, 8'hff, 1, ST_DONE, 255, 255, 255));
    rows.push_back(mk_row(KIND_ALLOC, 8'h00, 1, ST_DONE, 254, 254, 254));
    rows.push_back(mk_row(KIND_FREE,  8'haa, 1, ST_DONE, 170, 170, 255));
    rows.push_back(mk_row(KIND_ALLOC, 8'h00, 1, ST_DONE, 170, 170, 254));
    rows.push_back(mk_row(KIND_FREE,  8'h00, 1, ST_DONE, 0, 0, 255));
    rows.push_back(mk_row(KIND_FREE,  8'hff, 1, ST_DONE, 255, 255, 256));
    rows.push_back(mk_row(KIND_FREE,  8'h01, 1, ST_FREE_FULL, 0, 0, 256));
    rows.push_back(mk_row(KIND_ALLOC, 8'h5a, 1, ST_DONE, 255, 255, 255));
    // a freed block comes straight back on the next allocate
    rows.push_back(mk_row(KIND_FREE,  8'hff, 1, ST_DONE, 255, 255, 256));
    rows.push_back(mk_row(KIND_ALLOC, 8'h00, 1, ST_DONE, 255, 255, 255));
    rows.push_back(mk_row(KIND_ALLOC, 8'hff, 1, ST_DONE, 0, 0, 254));
    rows.push_back(mk_row(KIND_FREE,  8'h80, 0, ST_DONE, 0, 0, 0));
    rows.push_back(mk_row(KIND_FREE,  8'h7f, 0, ST_DONE, 0, 0, 0));
    rows.push_back(mk_row(KIND_ALLOC, 8'h00, 0, ST_DONE, 0, 0, 0));
    rows.push_back(mk_row(KIND_ALLOC, 8'h00, 0, ST_DONE, 0, 0, 0));
    rows.push_back(mk_row(KIND_ALLOC, 8'h00, 0, ST_DONE, 0, 0, 0));
    foreach (rows[i]) issue(rows[i].req, 0, rows[i].typed, rows[i].rsp);
    held.delete();

    sizes    = '{13'd0, 13'd8191, 13'd4096, 13'd1, 13'd3,
                 BlockSizeW'($urandom_range(1, 4096))};
    idle_pct = '{0, 46, 14, 0, 46, 14};
    draining = 1'b1;
    quiet    = 1'b0;

    for (int ph = 0; ph < Phases; ph++) begin
      drain();
      set_block_size(sizes[ph]);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (n == ItemsPerPhase / 2) drain();
        // sweep the pool between empty and full so both failure cases come up
        if (top_cnt == 0) draining = 1'b0;
        else if (top_cnt == Blocks) draining = 1'b1;
        else if ($urandom_range(0, 399) == 0) draining = !draining;
        r.block_index = IndexW'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
          r.kind = 1'($urandom_range(0, 1));
        end else begin
          r.kind = ($urandom_range(0, 99) < (draining ? 75 : 25)) ? KIND_ALLOC : KIND_FREE;
          // mostly give back a block that is really out
          if (r.kind == KIND_FREE && held.size() != 0 && $urandom_range(0, 99) < 90) begin
            k = $urandom_range(0, held.size() - 1);
            r.block_index = held[k];
            held.delete(k);
          end
        end
        gap = (!quiet && $urandom_range(0, 99) < idle_pct[ph]) ? $urandom_range(1, 4) : 0;
        issue(r, gap, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d requests over %0d block sizes, zero and all ones among them",
             n_alloc + n_empty + n_free + n_full, n_sizes + 1);
    $display("grants %0d, allocates on empty pool %0d, frees %0d, frees on full pool %0d",
             n_alloc, n_empty, n_free, n_full);
    if (errors == 0 && grants_due.size() == 0) begin
      $display("PASS fixed_block_free_stack_allocator");
    end else begin
      $display("FAIL fixed_block_free_stack_allocator");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fbfs_pkg.sv
src/fixed_block_free_stack_allocator.sv
bench/testbench.sv
